// ===== design/azs_pkg.sv =====
// Shared types and constants for the absolute z-score block.
// Used by azs_ctrl, azs_dp and absolute_z_score_block; depends on nothing.
package azs_pkg;

    localparam int DEPTH       = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 6;
    localparam int SCORE_W     = 16;
    localparam int FRAC_W      = 8;
    // Sum, deviation and square widths follow from sample width and count.
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int E_W         = SAMPLE_BITS + CNT_W + 1;
    localparam int A_W         = E_W - 1;
    localparam int SQ_W        = 2 * A_W;
    localparam int Q_W         = SQ_W + CNT_W;
    localparam int NUM_W       = SQ_W + CNT_W;
    // Quotient of n*a*a/Q scaled by 2^(2*FRAC_W) stays below DEPTH * 2^(2*FRAC_W).
    localparam int QUO_W       = CNT_W + 2 * FRAC_W;
    localparam int R_W         = (QUO_W + 1) / 2;
    localparam int STEP_W      = $clog2(QUO_W + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } req_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   position;
        logic               dropped;
        logic               end_of_run;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic blk_clr;
        logic q_clr;
        logic idx_clr;
        logic idx_inc;
        logic calc_e;
        logic calc_sq;
        logic acc_q;
        logic calc_num;
        logic div_ld;
        logic div_step;
        logic sqrt_ld;
        logic sqrt_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic q_zero;
        logic out_free;
    } stat_t;

endpackage

// ===== design/azs_ctrl.sv =====
// Sequencer for the absolute z-score block: walks load, variance and score phases.
// Depends on azs_pkg; drives azs_dp through cmd_t and reads stat_t.
module azs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           final_sample,
    output logic           req_stall,
    input  azs_pkg::stat_t stat,
    output azs_pkg::cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_LOAD   = 14'b00000000000001,
        S_Q_RD   = 14'b00000000000010,
        S_Q_E    = 14'b00000000000100,
        S_Q_SQ   = 14'b00000000001000,
        S_Q_ACC  = 14'b00000000010000,
        S_S_RD   = 14'b00000000100000,
        S_S_E    = 14'b00000001000000,
        S_S_SQ   = 14'b00000010000000,
        S_S_NUM  = 14'b00000100000000,
        S_DIV_LD = 14'b00001000000000,
        S_DIV    = 14'b00010000000000,
        S_SQ_LD  = 14'b00100000000000,
        S_SQRT   = 14'b01000000000000,
        S_EMIT   = 14'b10000000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [azs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        take;

    assign req_stall = (state_reg != S_LOAD);
    assign take      = req_valid && (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (take)
                begin
                    cmd.load = 1'b1;
                    if (final_sample)
                    begin
                        cmd.q_clr   = 1'b1;
                        cmd.idx_clr = 1'b1;
                        state_next  = S_Q_RD;
                    end
                end
            end
            S_Q_RD:  state_next = S_Q_E;
            S_Q_E:
            begin
                cmd.calc_e = 1'b1;
                state_next = S_Q_SQ;
            end
            S_Q_SQ:
            begin
                cmd.calc_sq = 1'b1;
                state_next  = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                cmd.acc_q = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
                state_next = stat.idx_last ? S_S_RD : S_Q_RD;
            end
            S_S_RD:  state_next = S_S_E;
            S_S_E:
            begin
                cmd.calc_e = 1'b1;
                // A flat block scores zero everywhere, so the divide is skipped.
                state_next = stat.q_zero ? S_EMIT : S_S_SQ;
            end
            S_S_SQ:
            begin
                cmd.calc_sq = 1'b1;
                state_next  = S_S_NUM;
            end
            S_S_NUM:
            begin
                cmd.calc_num = 1'b1;
                state_next   = S_DIV_LD;
            end
            S_DIV_LD:
            begin
                cmd.div_ld = 1'b1;
                step_next  = azs_pkg::STEP_W'(azs_pkg::QUO_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_SQ_LD;
                end
            end
            S_SQ_LD:
            begin
                cmd.sqrt_ld = 1'b1;
                step_next   = azs_pkg::STEP_W'(azs_pkg::R_W - 1);
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.idx_last)
                    begin
                        cmd.blk_clr = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_S_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== design/azs_dp.sv =====
// Datapath of the absolute z-score block: sample memory, sums, divider, root, output word.
// Depends on azs_pkg; controlled by azs_ctrl through cmd_t.
module azs_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  azs_pkg::req_t  req,
    input  azs_pkg::cmd_t  cmd,
    output azs_pkg::stat_t stat,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output azs_pkg::rsp_t  rsp
);

    logic signed [azs_pkg::SAMPLE_BITS-1:0] mem [azs_pkg::DEPTH];
    logic signed [azs_pkg::SAMPLE_BITS-1:0] rdata_reg;

    logic [azs_pkg::CNT_W-1:0]         count_reg;
    logic signed [azs_pkg::SUM_W-1:0]  sum_reg;
    logic                              ovf_reg;
    logic [azs_pkg::ADDR_W-1:0]        idx_reg;

    logic signed [azs_pkg::E_W-1:0]    e_reg, e_next;
    logic [azs_pkg::A_W-1:0]           a_mag;
    logic [azs_pkg::SQ_W-1:0]          sq_reg;
    logic [azs_pkg::Q_W-1:0]           q_reg;
    logic [azs_pkg::NUM_W-1:0]         num_reg;

    logic [azs_pkg::Q_W-1:0]           rem_reg;
    logic [azs_pkg::CNT_W-1:0]         dsh_reg;
    logic [azs_pkg::QUO_W-1:0]         quo_reg;
    logic [azs_pkg::Q_W:0]             trial;

    logic [azs_pkg::QUO_W-1:0]         v_reg, root_reg, bit_reg, rb;

    logic                              full;
    logic [azs_pkg::SCORE_W-1:0]       score_val;
    logic                              out_take;

    assign full     = (count_reg == azs_pkg::CNT_W'(azs_pkg::DEPTH));
    assign out_take = rsp_valid && !rsp_stall;

    assign stat.idx_last = ({1'b0, idx_reg} == azs_pkg::CNT_W'(count_reg - 1'b1));
    assign stat.q_zero   = (q_reg == '0);
    assign stat.out_free = !rsp_valid || !rsp_stall;

    // e = n*x - S in exact signed arithmetic.
    assign e_next = $signed({1'b0, count_reg}) * rdata_reg - sum_reg;
    assign a_mag  = e_reg[azs_pkg::E_W-1] ? azs_pkg::A_W'(-e_reg) : azs_pkg::A_W'(e_reg);

    // Remainder shifted left with the next dividend bit appended.
    assign trial = {rem_reg, dsh_reg[azs_pkg::CNT_W-1]};
    assign rb    = root_reg + bit_reg;

    assign score_val = stat.q_zero ? '0 : azs_pkg::SCORE_W'(root_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[count_reg[azs_pkg::ADDR_W-1:0]] <= req.sample;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_e)
        begin
            e_reg <= e_next;
        end
        if (cmd.calc_sq)
        begin
            sq_reg <= a_mag * a_mag;
        end
        if (cmd.calc_num)
        begin
            num_reg <= count_reg * sq_reg;
        end
        if (cmd.div_ld)
        begin
            rem_reg <= azs_pkg::Q_W'(num_reg >> azs_pkg::CNT_W);
            dsh_reg <= num_reg[azs_pkg::CNT_W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= {dsh_reg[azs_pkg::CNT_W-2:0], 1'b0};
            if (trial >= {1'b0, q_reg})
            begin
                rem_reg <= azs_pkg::Q_W'(trial - {1'b0, q_reg});
                quo_reg <= {quo_reg[azs_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= azs_pkg::Q_W'(trial);
                quo_reg <= {quo_reg[azs_pkg::QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_ld)
        begin
            v_reg    <= quo_reg;
            root_reg <= '0;
            bit_reg  <= azs_pkg::QUO_W'(1) << (2 * (azs_pkg::R_W - 1));
        end
        else if (cmd.sqrt_step)
        begin
            bit_reg <= bit_reg >> 2;
            if (v_reg >= rb)
            begin
                v_reg    <= v_reg - rb;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp.score      <= score_val;
            rsp.position   <= azs_pkg::POS_W'(idx_reg);
            rsp.dropped    <= stat.idx_last && ovf_reg;
            rsp.end_of_run <= stat.idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            q_reg     <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            if (cmd.blk_clr)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + azs_pkg::SUM_W'(req.sample);
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.q_clr)
            begin
                q_reg <= '0;
            end
            else if (cmd.acc_q)
            begin
                q_reg <= q_reg + azs_pkg::Q_W'(sq_reg);
            end
            if (cmd.emit)
            begin
                rsp_valid <= 1'b1;
            end
            else if (out_take)
            begin
                rsp_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/absolute_z_score_block.sv =====
// Absolute z-score block: top level joining azs_ctrl and azs_dp (uses azs_pkg).
// Operation: samples load one per cycle while no block is being scored; after the final
// word, each sample is read, its deviation formed, squared and added to the squared
// deviation sum; then each score passes memory read, multiplies, the restoring divider and
// square root unit; with zero deviation it skips to output; output stalls hold the sequence.
// Throughput: one block at a time; no new sample is taken until the last score is latched.
// Reset: rst_n asynchronously empties the block and clears the output valid.
module absolute_z_score_block (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  azs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output azs_pkg::rsp_t rsp
);

    azs_pkg::cmd_t  cmd;
    azs_pkg::stat_t stat;

    azs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .final_sample (req.final_sample),
        .req_stall    (req_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    azs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
